[rtl/ppe_pkg.sv]
// Shared types, widths and register map of the partial permutation enumerator.
package ppe_pkg;

   localparam int NUM_SLOTS    = 7;
   localparam int LETTER_W     = 8;
   localparam int DIGIT_W      = 3;
   localparam int LEVEL_W      = 3;
   localparam int COUNT_W      = 4;
   localparam int RACK_W       = NUM_SLOTS * LETTER_W;
   localparam int RACK_LEN_W   = 3;

   localparam int RACK_MAX_DEF = 7;
   localparam int LONGEST_DEF  = 7;

   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_SEL_BIT  = 3;

   localparam logic CSR_IDX_LETTERS = 1'b0;
   localparam logic CSR_IDX_LENGTH  = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_FIRST = 3'd2;

   typedef logic [LETTER_W-1:0]                  letter_type;
   typedef logic [NUM_SLOTS-1:0][LETTER_W-1:0]   word_type;
   typedef logic [NUM_SLOTS-1:0][DIGIT_W-1:0]    digit_vec_type;

   typedef struct packed {
      logic start;
      logic restart;
      logic finish;
      logic pick;
      logic advance;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic last_pick;
   } status_type;

endpackage

[rtl/ppe_ctrl.sv]
// Sequencer for the enumerator: accepts a beat, steps the datapath, presents the result.
module ppe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_restart,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  ppe_pkg::status_type status,
   output ppe_pkg::cmd_type   cmd
);
   import ppe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PICK,
      ST_ADVANCE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.restart = req_restart;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bad) begin
               cmd.finish = 1'b1;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            if (status.last_pick) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // The output register may be refilled as soon as its current beat leaves.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/ppe_dpath.sv]
// Datapath of the enumerator: pick digits, remaining-letter list and result register.
module ppe_dpath #(
   parameter int RACK_MAX = ppe_pkg::RACK_MAX_DEF,
   parameter int LONGEST  = ppe_pkg::LONGEST_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ppe_pkg::cmd_type                      cmd,
   output ppe_pkg::status_type                   status,
   input  logic [ppe_pkg::RACK_W-1:0]            rack_letters,
   input  logic [ppe_pkg::RACK_LEN_W-1:0]        rack_length,
   output ppe_pkg::word_type                     rsp_word,
   output logic [ppe_pkg::LEVEL_W-1:0]           rsp_length,
   output logic                                  rsp_done
);
   import ppe_pkg::*;

   // Enumeration state, kept across beats.
   digit_vec_type        digit_ff, digit_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 fin_ff, fin_in;

   // Working registers for one selection.
   word_type             left_ff, left_sh;
   logic [DIGIT_W-1:0]   size_ff;
   logic [DIGIT_W-1:0]   slot_ff;
   word_type             word_ff;
   logic [LEVEL_W-1:0]   len_ff;
   logic                 done_ff;

   word_type             rsp_word_ff;
   logic [LEVEL_W-1:0]   rsp_length_ff;
   logic                 rsp_done_ff;

   logic [COUNT_W-1:0]   rack_n;
   logic [COUNT_W-1:0]   top_n;
   logic [DIGIT_W-1:0]   pick_digit;
   logic [DIGIT_W-1:0]   pick_idx;
   letter_type           pick_letter;
   logic                 hit_found;
   logic [DIGIT_W-1:0]   hit_idx;
   logic [COUNT_W-1:0]   lim;
   digit_vec_type        digit_adv;

   always_comb begin
      rack_n = {1'b0, rack_length};
      if (rack_n > COUNT_W'(RACK_MAX)) begin
         rack_n = COUNT_W'(RACK_MAX);
      end
      top_n = (COUNT_W'(LONGEST) < rack_n) ? COUNT_W'(LONGEST) : rack_n;
   end

   assign status.bad = fin_ff || (rack_n < 4'd2) || (level_ff < LEVEL_FIRST) ||
                       ({1'b0, level_ff} > top_n);
   assign status.last_pick = (slot_ff == (level_ff - 3'd1));

   // One pick: a stale digit past the end takes the last letter left.
   always_comb begin
      pick_digit  = digit_ff[slot_ff];
      pick_idx    = (pick_digit >= size_ff) ? (size_ff - 3'd1) : pick_digit;
      pick_letter = left_ff[pick_idx];
      left_sh     = left_ff;
      for (int k = 0; k < NUM_SLOTS - 1; k++) begin
         if (DIGIT_W'(k) >= pick_idx) begin
            left_sh[k] = left_ff[k + 1];
         end
      end
   end

   // Odometer step: the highest digit below the level that can still grow takes the carry.
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      lim       = '0;
      for (int d = 0; d < NUM_SLOTS; d++) begin
         lim = rack_n - COUNT_W'(d);
         if ((DIGIT_W'(d) < level_ff) && (({1'b0, digit_ff[d]} + 4'd1) < lim)) begin
            hit_found = 1'b1;
            hit_idx   = DIGIT_W'(d);
         end
      end
      for (int d = 0; d < NUM_SLOTS; d++) begin
         if (!hit_found || (DIGIT_W'(d) > hit_idx)) begin
            digit_adv[d] = '0;
         end else if (DIGIT_W'(d) == hit_idx) begin
            digit_adv[d] = digit_ff[d] + 3'd1;
         end else begin
            digit_adv[d] = digit_ff[d];
         end
      end
   end

   always_comb begin
      digit_in = digit_ff;
      level_in = level_ff;
      fin_in   = fin_ff;
      if (cmd.start && cmd.restart) begin
         digit_in = '0;
         level_in = LEVEL_FIRST;
         fin_in   = 1'b0;
      end
      if (cmd.finish) begin
         fin_in = 1'b1;
      end
      if (cmd.advance) begin
         digit_in = digit_adv;
         if (!hit_found) begin
            if (({1'b0, level_ff} + 4'd1) > top_n) begin
               fin_in = 1'b1;
            end else begin
               level_in = level_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
         level_ff <= LEVEL_FIRST;
         fin_ff   <= 1'b0;
      end else begin
         digit_ff <= digit_in;
         level_ff <= level_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            left_ff[k] <= rack_letters[LETTER_W*k +: LETTER_W];
         end
         size_ff <= rack_n[DIGIT_W-1:0];
         slot_ff <= '0;
         word_ff <= '0;
         len_ff  <= '0;
         done_ff <= 1'b0;
      end
      if (cmd.finish) begin
         done_ff <= 1'b1;
      end
      if (cmd.pick) begin
         word_ff[slot_ff] <= pick_letter;
         left_ff          <= left_sh;
         size_ff          <= size_ff - 3'd1;
         slot_ff          <= slot_ff + 3'd1;
      end
      if (cmd.advance) begin
         len_ff <= level_ff;
      end
      if (cmd.emit) begin
         rsp_word_ff   <= word_ff;
         rsp_length_ff <= len_ff;
         rsp_done_ff   <= done_ff;
      end
   end

   assign rsp_word   = rsp_word_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_done   = rsp_done_ff;

endmodule

[rtl/partial_permutation_enumerator_top.sv]
// Top level of the partial permutation enumerator: register port, sequencer and datapath.
//
// Each request beat carries one bit, req_restart. A 1 starts again at the first
// two-letter selection, a 0 moves on to the next one. Every request gives exactly
// one response beat: the selection's letters (letter_a first, unused letters zero)
// and its word_length, or done_res set with everything else zero once all lengths
// from two up to min(rack size, LONGEST) are used up. Done holds until a restart.
// The rack is written through the register port: rack_letters at byte address 0
// and rack_length at byte address 8; both read back. Write them only while idle.
// A selection passes through the check, the pick loop and the advance step before
// it is emitted; a done beat goes from the check straight to emit. The pick loop
// removes one chosen letter from the remaining list per cycle.
// A new request is taken only once the previous response sits in the output
// register. If the receiver stalls, the response holds and the block waits before
// loading the next one. Reset clears the rack registers and restarts the sequence.
module partial_permutation_enumerator_top #(
   parameter int RACK_MAX = ppe_pkg::RACK_MAX_DEF,
   parameter int LONGEST  = ppe_pkg::LONGEST_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ppe_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ppe_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ppe_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ppe_pkg::LETTER_W-1:0]      rsp_letter_a,
   output logic [ppe_pkg::LETTER_W-1:0]      rsp_letter_b,
   output logic [ppe_pkg::LETTER_W-1:0]      rsp_letter_c,
   output logic [ppe_pkg::LETTER_W-1:0]      rsp_letter_d,
   output logic [ppe_pkg::LETTER_W-1:0]      rsp_letter_e,
   output logic [ppe_pkg::LETTER_W-1:0]      rsp_letter_f,
   output logic [ppe_pkg::LETTER_W-1:0]      rsp_letter_g,
   output logic [ppe_pkg::LEVEL_W-1:0]       rsp_word_length,
   output logic                              rsp_done_res
);
   import ppe_pkg::*;

   logic [RACK_W-1:0]     rack_letters_ff;
   logic [RACK_LEN_W-1:0] rack_length_ff;
   logic                  csr_write;
   cmd_type               cmd;
   status_type            status;
   word_type              rsp_word;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rack_letters_ff <= '0;
         rack_length_ff  <= '0;
      end else if (csr_write) begin
         unique case (paddr[CSR_SEL_BIT])
            CSR_IDX_LETTERS: rack_letters_ff <= pwdata[RACK_W-1:0];
            CSR_IDX_LENGTH:  rack_length_ff  <= pwdata[RACK_LEN_W-1:0];
            default:         rack_length_ff  <= rack_length_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[CSR_SEL_BIT])
         CSR_IDX_LETTERS: prdata = CSR_DATA_W'(rack_letters_ff);
         CSR_IDX_LENGTH:  prdata = CSR_DATA_W'(rack_length_ff);
         default:         prdata = '0;
      endcase
   end

   ppe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   ppe_dpath #(
      .RACK_MAX (RACK_MAX),
      .LONGEST  (LONGEST)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .rack_letters (rack_letters_ff),
      .rack_length  (rack_length_ff),
      .rsp_word     (rsp_word),
      .rsp_length   (rsp_word_length),
      .rsp_done     (rsp_done_res)
   );

   assign rsp_letter_a = rsp_word[0];
   assign rsp_letter_b = rsp_word[1];
   assign rsp_letter_c = rsp_word[2];
   assign rsp_letter_d = rsp_word[3];
   assign rsp_letter_e = rsp_word[4];
   assign rsp_letter_f = rsp_word[5];
   assign rsp_letter_g = rsp_word[6];

endmodule
